// ----- hdl/u2u_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types, codes and byte classification for the UTF-8 to UTF-16
// transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam logic [15:0] BAD_UNIT = 16'h0023;

    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_ONE     = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    localparam int MAX_UNITS = 3;

    typedef logic [15:0] unit_t;

    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [1:0]                 count;
        logic                       is_last;
    } unit_group_t;

    typedef struct packed {
        logic [2:0] open_len;
        logic [1:0] held_count;
    } seq_status_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            unique case (b[7:3]) inside
                [5'b00000:5'b01111]: len = LEN_ONE;
                [5'b11000:5'b11011]: len = LEN_TWO;
                [5'b11100:5'b11101]: len = LEN_THREE;
                5'b11110:            len = LEN_FOUR;
                default:             len = LEN_INVALID;
            endcase
            return len;
        end
    endfunction

    function automatic unit_t single_unit(input logic [7:0] b);
        return (seq_len(b) == LEN_ONE) ? {9'd0, b[6:0]} : BAD_UNIT;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/u2u_byte_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_byte_if
// Valid/ready channel carrying one UTF-8 byte per beat.
// ----------------------------------------------------------------------------
interface u2u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/u2u_unit_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_unit_if
// Valid/ready channel carrying one UTF-16 code unit per beat.
// ----------------------------------------------------------------------------
interface u2u_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        final_unit;

    modport source (output valid, output code_unit, output final_unit, input ready);
    modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface
`default_nettype wire

// ----- hdl/u2u_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_decoder
// Holds the open UTF-8 sequence and decodes the registered byte into a group
// of up to three UTF-16 code units.
// ----------------------------------------------------------------------------
module u2u_decoder
    import u2u_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  byte_in,
    input  wire logic        last_byte,
    output unit_group_t      group,
    output seq_status_t      status
);

    logic [2:0][7:0] held_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic [2:0]      open_reg;
    logic [2:0]      open_next;

    logic [2:0]  lead_len;
    logic        hold;
    logic [2:0]  n_bytes;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [20:0] cp;
    logic [20:0] cp_ofs;
    unit_t       hi_unit;
    unit_t       lo_unit;

    always_comb
    begin
        lead_len = seq_len(byte_in);
        n_bytes  = {1'b0, count_reg} + 3'd1;
        hold     = !last_byte &&
                   (((open_reg == LEN_INVALID) && (lead_len >= LEN_TWO)) ||
                    ((open_reg != LEN_INVALID) && (n_bytes < open_reg)));

        b0 = held_reg[0];
        b1 = (count_reg >= 2'd2) ? held_reg[1] : byte_in;
        b2 = (count_reg == 2'd3) ? held_reg[2] : byte_in;

        case (open_reg)
            LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
            LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            default:   cp = {b0[2:0], b1[5:0], b2[5:0], byte_in[5:0]};
        endcase
        cp_ofs  = cp - 21'h010000;
        hi_unit = 16'hD800 + {5'd0, cp_ofs[20:10]};
        lo_unit = 16'hDC00 + {6'd0, cp_ofs[9:0]};
    end

    always_comb
    begin
        group.units   = '0;
        group.count   = 2'd0;
        group.is_last = last_byte;
        if (!hold)
        begin
            if (open_reg == LEN_INVALID)
            begin
                group.units[0] = single_unit(byte_in);
                group.count    = 2'd1;
            end
            else if (n_bytes == open_reg)
            begin
                if (cp[20:16] != 5'd0)
                begin
                    group.units[0] = hi_unit;
                    group.units[1] = lo_unit;
                    group.count    = 2'd2;
                end
                else
                begin
                    group.units[0] = cp[15:0];
                    group.count    = 2'd1;
                end
            end
            else
            begin
                group.units[0] = BAD_UNIT;
                if (count_reg == 2'd1)
                begin
                    group.units[1] = single_unit(byte_in);
                    group.count    = 2'd2;
                end
                else if (seq_len(b1) == LEN_TWO)
                begin
                    group.units[1] = {5'd0, b1[4:0], byte_in[5:0]};
                    group.count    = 2'd2;
                end
                else
                begin
                    group.units[1] = single_unit(b1);
                    group.units[2] = single_unit(byte_in);
                    group.count    = 2'd3;
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        if (fire)
        begin
            if (hold)
            begin
                count_next = count_reg + 2'd1;
                open_next  = (open_reg == LEN_INVALID) ? lead_len : open_reg;
            end
            else
            begin
                count_next = 2'd0;
                open_next  = LEN_INVALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            open_reg  <= LEN_INVALID;
        end
        else
        begin
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && hold)
        begin
            held_reg[count_reg] <= byte_in;
        end
    end

    assign status.open_len   = open_reg;
    assign status.held_count = count_reg;

endmodule
`default_nettype wire

// ----- hdl/u2u_unit_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_unit_buf
// Output register for one group of code units; sends one unit per beat.
// ----------------------------------------------------------------------------
module u2u_unit_buf
    import u2u_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire unit_group_t  group,
    output logic              can_load,
    u2u_unit_if.source        utf16
);

    logic [MAX_UNITS-1:0][15:0] units_reg;
    logic [MAX_UNITS-1:0][15:0] units_next;
    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       beat;

    assign beat     = utf16.valid && utf16.ready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && utf16.ready);

    always_comb
    begin
        units_next = units_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        if (load)
        begin
            units_next = group.units;
            cnt_next   = group.count;
            last_next  = group.is_last;
        end
        else if (beat)
        begin
            units_next = {16'd0, units_reg[2], units_reg[1]};
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        units_reg <= units_next;
        last_reg  <= last_next;
    end

    assign utf16.valid      = (cnt_reg != 2'd0);
    assign utf16.code_unit  = units_reg[0];
    assign utf16.final_unit = last_reg && (cnt_reg == 2'd1);

endmodule
`default_nettype wire

// ----- hdl/utf8_to_utf16_transcoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code unit stream out.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per beat and can accept a byte every cycle while the
// output side keeps up. A byte passes an input register, is decoded against
// the open sequence, and its code units are loaded into an output register
// when the decoder accepts it from the input register. The output register
// sends one unit per cycle while the sink is ready, and a byte that yields
// k units (0 to 3), such as a surrogate pair or a broken-off sequence, holds
// the input side until its last unit goes out. Invalid leads give '#'; the
// last unit caused by the string's last byte carries final_unit.
module utf8_to_utf16_transcoder_top
    import u2u_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    u2u_byte_if.sink    utf8,
    u2u_unit_if.source  utf16
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        fire;
    logic        can_load;
    unit_group_t group;
    seq_status_t status;

    assign fire       = in_valid_reg && ((group.count == 2'd0) || can_load);
    assign utf8.ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (utf8.valid && utf8.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (utf8.valid && utf8.ready)
        begin
            in_byte_reg <= utf8.byte_in;
            in_last_reg <= utf8.last_byte;
        end
    end

    u2u_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_in   (in_byte_reg),
        .last_byte (in_last_reg),
        .group     (group),
        .status    (status)
    );

    u2u_unit_buf u_unit_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && (group.count != 2'd0)),
        .group    (group),
        .can_load (can_load),
        .utf16    (utf16)
    );

    a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (status.open_len == LEN_INVALID) |-> (status.held_count == 2'd0))
        else $error("held bytes without an open sequence");

    a_open_bounds : assert property (@(posedge clk) disable iff (!rst_n)
        (status.open_len != LEN_INVALID) |->
            ((status.held_count != 2'd0) &&
             ({1'b0, status.held_count} < status.open_len)))
        else $error("held count out of range for open sequence");

    a_last_closes : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> (status.open_len == LEN_INVALID))
        else $error("sequence left open after last byte");

    a_last_emits : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |-> (group.count != 2'd0))
        else $error("last byte produced no code unit");

endmodule
`default_nettype wire

// ----- tb/sv/utf8_to_utf16_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_checker
// Watches the byte and code unit channels of the transcoder. Every accepted
// byte is run through a local UTF-8 decoder that keeps its own copy of the
// open sequence, and the code units it yields are queued. Every accepted
// code unit beat is compared against the oldest queued unit.
// ----------------------------------------------------------------------------
module utf8_to_utf16_checker
    import u2u_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    u2u_byte_if   utf8,
    u2u_unit_if   utf16,
    output int    errors,
    output int    pending
);

    typedef struct {
        logic [15:0] code;
        logic        fin;
    } utf16_unit_t;

    utf16_unit_t utf16_expected [$];

    logic [7:0] pend_bytes [3];
    logic [1:0] pend_count;
    logic [2:0] seq_open_len;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        if (b < 8'h80) return LEN_ONE;
        if (b < 8'hC0) return LEN_INVALID;
        if (b < 8'hE0) return LEN_TWO;
        if (b < 8'hF0) return LEN_THREE;
        if (b < 8'hF8) return LEN_FOUR;
        return LEN_INVALID;
    endfunction

    task automatic transcode_byte(input logic [7:0] b, input logic is_last);
        logic [7:0]  run [4];
        logic [15:0] units [$];
        logic [20:0] cp;
        logic [20:0] off;
        logic [2:0]  len;
        int          n;
        int          i;
        int          n_out;
        utf16_unit_t u;
        if (seq_open_len == 3'd0)
        begin
            len = lead_len(b);
            if (!is_last && len >= LEN_TWO)
            begin
                pend_bytes[0] = b;
                pend_count    = 2'd1;
                seq_open_len  = len;
                return;
            end
        end
        else if (!is_last && int'(pend_count) + 1 < int'(seq_open_len) && pend_count < 2'd3)
        begin
            pend_bytes[pend_count] = b;
            pend_count             = pend_count + 2'd1;
            return;
        end

        n = int'(pend_count);
        for (i = 0; i < n; i++)
            run[i] = pend_bytes[i];
        run[n] = b;
        n      = n + 1;

        // decode what remains from left to right, each byte taken as a lead
        i = 0;
        while (i < n)
        begin
            len = lead_len(run[i]);
            if (len == LEN_INVALID || int'(len) > n - i)
            begin
                units.push_back(BAD_UNIT);
                i = i + 1;
            end
            else
            begin
                case (len)
                    LEN_ONE:   cp = {14'd0, run[i][6:0]};
                    LEN_TWO:   cp = {10'd0, run[i][4:0], run[i+1][5:0]};
                    LEN_THREE: cp = {5'd0, run[i][3:0], run[i+1][5:0], run[i+2][5:0]};
                    default:   cp = {run[i][2:0], run[i+1][5:0], run[i+2][5:0],
                                     run[i+3][5:0]};
                endcase
                if (cp < 21'h010000)
                    units.push_back(cp[15:0]);
                else
                begin
                    off = cp - 21'h010000;
                    units.push_back(16'hD800 + {5'd0, off[20:10]});
                    units.push_back(16'hDC00 + {6'd0, off[9:0]});
                end
                i = i + int'(len);
            end
        end

        pend_count   = 2'd0;
        seq_open_len = 3'd0;

        n_out = (units.size() < MAX_UNITS) ? units.size() : MAX_UNITS;
        for (i = 0; i < n_out; i++)
        begin
            u.code = units[i];
            u.fin  = is_last && (i == n_out - 1);
            utf16_expected.push_back(u);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utf16_unit_t want;
        if (!rst_n)
        begin
            utf16_expected.delete();
            pend_count   = 2'd0;
            seq_open_len = 3'd0;
            errors       = 0;
            pending      = 0;
        end
        else
        begin
            if (utf8.valid && utf8.ready)
                transcode_byte(utf8.byte_in, utf8.last_byte);
            if (utf16.valid && utf16.ready)
            begin
                if (utf16_expected.size() == 0)
                begin
                    $error("unexpected beat: code_unit %h final_unit %b",
                           utf16.code_unit, utf16.final_unit);
                    errors = errors + 1;
                end
                else
                begin
                    want = utf16_expected.pop_front();
                    if (utf16.code_unit !== want.code)
                    begin
                        $error("code_unit: expected %h, actual %h", want.code, utf16.code_unit);
                        errors = errors + 1;
                    end
                    if (utf16.final_unit !== want.fin)
                    begin
                        $error("final_unit: expected %b, actual %b", want.fin,
                               utf16.final_unit);
                        errors = errors + 1;
                    end
                end
            end
            pending = utf16_expected.size();
        end
    end

endmodule

// ----- tb/sv/tb_utf8_to_utf16_transcoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder_top
// Testbench for the UTF-8 to UTF-16 transcoder. Sends a directed set of
// byte strings (range limits, every sequence length, overlong and
// out-of-range forms, invalid leads, strings cut off inside a sequence),
// then random strings, mostly well-formed characters with random content
// mixed with loose bytes and cut-off sequences. Both channels idle at
// random. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_top;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_BYTES = 280;
    localparam int DRAIN_CYCLES = 16;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   units_pending;
    int   cycle_count = 0;
    bit   in_burst    = 1'b0;
    bit   out_burst   = 1'b0;

    u2u_byte_if utf8 ();
    u2u_unit_if utf16 ();

    utf8_to_utf16_transcoder_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8),
        .utf16 (utf16)
    );

    utf8_to_utf16_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .utf8    (utf8),
        .utf16   (utf16),
        .errors  (fail_count),
        .pending (units_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if ($urandom_range(0, 15) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            utf8.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        utf8.valid     <= 1'b1;
        utf8.byte_in   <= b;
        utf8.last_byte <= is_last;
        @(posedge clk);
        while (!utf8.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sink side: stall a random number of cycles, then take one beat
    initial
    begin
        int stall;
        utf16.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                utf16.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            utf16.ready <= 1'b1;
            @(posedge clk);
            while (!utf16.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        // {last_byte, byte_in}
        logic [8:0] directed_beats [24] = '{
            9'h100, 9'h07F, 9'h080, 9'h0C0, 9'h080, 9'h0EF, 9'h0BF, 9'h1BF,
            9'h0F0, 9'h090, 9'h080, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
            9'h0F8, 9'h1FF, 9'h1C3, 9'h0F0, 9'h041, 9'h1C3, 9'h0E2, 9'h182
        };
        logic [7:0] seq [4];
        int         sent;
        int         kind;
        int         len;
        int         cut;
        int         k;

        rst_n          = 1'b0;
        utf8.valid     = 1'b0;
        utf8.byte_in   = 8'h00;
        utf8.last_byte = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_beats[d])
            send_byte(directed_beats[d][7:0], directed_beats[d][8]);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 9);
            if (kind >= 7)
            begin
                send_byte(8'($urandom_range(0, 255)), kind == 9 || $urandom_range(0, 3) == 0);
                sent = sent + 1;
            end
            else
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       seq[0] = 8'($urandom_range(0, 127));
                    2:       seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
                    3:       seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
                    default: seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                for (k = 1; k < 4; k++)
                    seq[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'h80 | 8'($urandom_range(0, 63));
                cut = len;
                if (kind == 6 && len > 1)
                    cut = $urandom_range(1, len - 1);
                for (k = 0; k < cut; k++)
                    send_byte(seq[k], k == cut - 1 && (cut < len || $urandom_range(0, 5) == 0));
                sent = sent + cut;
            end
        end
        utf8.valid <= 1'b0;

        while (units_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
